@@ rtl/core/cctrl_pkg.sv @@
// Shared types and constants for the character class table loader.
`default_nettype none

package cctrl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned TABLE_DEPTH_MAX = 256;
  // Width that holds any byte and any write pointer value up to the table end.
  localparam int unsigned CMP_W   = 9;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_C     = 8'h63;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CARET_FLIP = 8'h40;

  localparam logic [1:0] CLS_NORMAL  = 2'b00;
  localparam logic [1:0] CLS_CONTROL = 2'b10;
  localparam logic [1:0] CLS_BINCTL  = 2'b11;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_END   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_LETTER = 2'd1,
    STAT_OVERFLOW   = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    FORM_PLAIN  = 2'd0,
    FORM_CARET  = 2'd1,
    FORM_ESCAPE = 2'd2
  } form_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_FILL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_binary;
    logic       is_control;
    logic [1:0] form;
    logic [7:0] shown_char;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the item and read both table entries
    logic digit;       // fold a digit into the repeat count
    logic set_invalid; // flag an invalid description letter
    logic run_start;   // load the run counter from the repeat count
    logic run_write;   // write one entry of a letter run
    logic run_done;    // run finished in bounds
    logic run_ovf;     // run hit the table end with entries left
    logic fill_write;  // write one entry of the end fill
    logic fill_done;   // end fill reached the table end
    logic emit;        // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic err_set;
    logic is_digit;
    logic is_letter;
    logic run_zero;
    logic table_full;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cctrl_datapath.sv @@
// Datapath: class table memory, load registers, query decode and result register.
`default_nettype none

module cctrl_datapath #(
  parameter int unsigned TableDepth = cctrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cctrl_pkg::in_item_t  in_item_i,
  input  cctrl_pkg::cmd_t      cmd_i,
  output cctrl_pkg::stat_t     stat_o,
  output cctrl_pkg::out_item_t out_item_o
);
  import cctrl_pkg::*;

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned PtrW  = $clog2(TableDepth + 1);
  localparam logic [PtrW-1:0] PtrEnd = PtrW'(TableDepth);

  logic [1:0] mem_q [TableDepth];

  logic [1:0]         req_q;
  logic [7:0]         byte_q;
  logic [1:0]         rd0_q, rd1_q;
  logic               v0_q, v1_q;
  logic [PtrW-1:0]    wp_q, wp_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] run_q, run_d;
  logic [1:0]         last_q, last_d;
  logic [1:0]         err_q, err_d;
  out_item_t          out_q, out_d;

  logic [7:0]  addr0, addr1;
  logic        is_digit, is_letter;
  logic [1:0]  letter_cls;
  logic [12:0] count_next;
  logic        mem_we;
  logic [1:0]  mem_wdata;
  logic [1:0]  cls0, cls1;

  assign addr0 = in_item_i.data_byte;
  assign addr1 = in_item_i.data_byte ^ CARET_FLIP;

  assign is_digit = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);

  always_comb begin
    is_letter  = 1'b1;
    letter_cls = CLS_NORMAL;
    priority if (byte_q == CHAR_DOT) begin
      letter_cls = CLS_NORMAL;
    end else if (byte_q == CHAR_C) begin
      letter_cls = CLS_CONTROL;
    end else if (byte_q == CHAR_B) begin
      letter_cls = CLS_BINCTL;
    end else begin
      is_letter = 1'b0;
    end
  end

  // count * 10 + digit, saturated below.
  assign count_next = ({4'b0, count_q} << 3) + ({4'b0, count_q} << 1)
                    + {9'b0, 4'(byte_q - CHAR_ZERO)};

  assign stat_o.req        = req_e'(req_q);
  assign stat_o.err_set    = (err_q != STAT_OK);
  assign stat_o.is_digit   = is_digit;
  assign stat_o.is_letter  = is_letter;
  assign stat_o.run_zero   = (run_q == '0);
  assign stat_o.table_full = (wp_q >= PtrEnd);

  always_comb begin
    wp_d      = wp_q;
    count_d   = count_q;
    run_d     = run_q;
    last_d    = last_q;
    err_d     = err_q;
    mem_we    = 1'b0;
    mem_wdata = letter_cls;
    if (cmd_i.digit) begin
      count_d = (count_next > 13'(COUNT_MAX)) ? COUNT_MAX : count_next[COUNT_W-1:0];
    end
    if (cmd_i.set_invalid) begin
      err_d = STAT_BAD_LETTER;
    end
    if (cmd_i.run_start) begin
      run_d = (count_q == '0) ? COUNT_W'(1) : count_q;
    end
    if (cmd_i.run_write) begin
      mem_we = 1'b1;
      wp_d   = wp_q + PtrW'(1);
      run_d  = run_q - COUNT_W'(1);
    end
    if (cmd_i.run_done || cmd_i.run_ovf) begin
      last_d  = letter_cls;
      count_d = '0;
    end
    if (cmd_i.run_ovf) begin
      err_d = STAT_OVERFLOW;
    end
    if (cmd_i.fill_write) begin
      mem_we    = 1'b1;
      mem_wdata = last_q;
      wp_d      = wp_q + PtrW'(1);
    end
    if (cmd_i.fill_done) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      count_q <= '0;
      run_q   <= '0;
      last_q  <= CLS_NORMAL;
      err_q   <= STAT_OK;
    end else begin
      wp_q    <= wp_d;
      count_q <= count_d;
      run_q   <= run_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  // Entries at or above the write pointer were never written since reset
  // and read as normal class, so the memory needs no clearing.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q[AddrW-1:0]] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      req_q  <= in_item_i.req_type;
      byte_q <= in_item_i.data_byte;
      rd0_q  <= mem_q[addr0[AddrW-1:0]];
      rd1_q  <= mem_q[addr1[AddrW-1:0]];
      v0_q   <= CMP_W'(addr0) < CMP_W'(wp_q);
      v1_q   <= CMP_W'(addr1) < CMP_W'(wp_q);
    end
  end

  assign cls0 = v0_q ? rd0_q : CLS_NORMAL;
  assign cls1 = v1_q ? rd1_q : CLS_NORMAL;

  always_comb begin
    out_d        = '0;
    out_d.status = err_q;
    if (req_e'(req_q) == REQ_QUERY) begin
      out_d.is_binary  = cls0[0];
      out_d.is_control = cls0[1];
      priority if (!cls0[1]) begin
        out_d.form       = FORM_PLAIN;
        out_d.shown_char = byte_q;
      end else if (!cls1[1]) begin
        out_d.form       = FORM_CARET;
        out_d.shown_char = byte_q ^ CARET_FLIP;
      end else begin
        out_d.form       = FORM_ESCAPE;
        out_d.shown_char = byte_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

@@ rtl/core/cctrl_ctrl.sv @@
// Controller: sequences each item through decode, table runs and result hand-off.
`default_nettype none

module cctrl_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  cctrl_pkg::stat_t  stat_i,
  output cctrl_pkg::cmd_t   cmd_o
);
  import cctrl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        if (!stat_i.err_set) begin
          if (stat_i.req == REQ_LOAD) begin
            priority if (stat_i.is_digit) begin
              cmd_o.digit = 1'b1;
            end else if (stat_i.is_letter) begin
              cmd_o.run_start = 1'b1;
              state_d         = ST_RUN;
            end else begin
              cmd_o.set_invalid = 1'b1;
            end
          end else if (stat_i.req == REQ_END) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_RUN: begin
        priority if (stat_i.run_zero) begin
          cmd_o.run_done = 1'b1;
          state_d        = ST_FINISH;
        end else if (stat_i.table_full) begin
          cmd_o.run_ovf = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.run_write = 1'b1;
        end
      end
      ST_FILL: begin
        if (stat_i.table_full) begin
          cmd_o.fill_done = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          cmd_o.fill_write = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/char_class_table_rle_loader_core.sv @@
// Top level of the character class table loader: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) carries one request per
// item: a description byte, an end of description, a query character or none.
// Output channel (out_valid_o/out_ready_i, out_item_o) returns exactly one
// result item per request, in order, with the sticky status and, for a
// query, the class bits and display form of the character.
// One item is processed at a time. A digit, an invalid letter, an ignored
// item or a query goes from decode straight to the result. A letter first
// writes its run into the table, one entry at a time (its repeat count, at
// least one, cut short at the table end). An end item without a sticky
// error first fills each remaining table entry with the last class. The
// next item is accepted the cycle after a result is loaded into the output
// register.
// Reset clears the write pointer, repeat count, last class and error at
// once; unwritten table entries read as normal, so no clearing pass runs.
// If the receiver stalls, the result waits in the output register; the
// next item is still accepted and processed, and holds only at hand-off.
`default_nettype none

module char_class_table_rle_loader_core #(
  parameter int unsigned TableDepth = cctrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  cctrl_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output cctrl_pkg::out_item_t out_item_o
);
  import cctrl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cctrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cctrl_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

@@ sim/char_class_table_rle_loader_core_tb.sv @@
// Self-checking testbench for the character class table loader: load, fill, errors, queries.
module char_class_table_rle_loader_core_tb;
  import cctrl_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  char_class_table_rle_loader_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted copy of the block state.
  logic [1:0]  class_model [TABLE_DEPTH_DEF];
  int unsigned model_wp;
  int unsigned model_count;
  logic [1:0]  model_last;
  logic [1:0]  model_err;

  out_item_t expected_results [$];

  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned queries_sent;
  int unsigned results_checked;
  int unsigned errors;
  int unsigned stall_left;
  int unsigned stall_mode;
  int unsigned wp_before_fill;
  bit          took_overflow_path;

  function automatic out_item_t predict_class_result(input in_item_t it);
    out_item_t   res;
    logic [1:0]  cls;
    logic [1:0]  letter_cls;
    logic [7:0]  b;
    logic        is_letter;
    int unsigned n;
    res = '0;
    b = it.data_byte;
    case (it.req_type)
      REQ_LOAD: begin
        if (model_err == STAT_OK) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            n = model_count * 10 + int'(b - CHAR_ZERO);
            model_count = (n > COUNT_MAX) ? COUNT_MAX : n;
          end else begin
            is_letter = 1'b1;
            letter_cls = CLS_NORMAL;
            if (b == CHAR_DOT) begin
              letter_cls = CLS_NORMAL;
            end else if (b == CHAR_C) begin
              letter_cls = CLS_CONTROL;
            end else if (b == CHAR_B) begin
              letter_cls = CLS_BINCTL;
            end else begin
              is_letter = 1'b0;
              model_err = STAT_BAD_LETTER;
            end
            if (is_letter) begin
              n = (model_count == 0) ? 1 : model_count;
              while (n > 0) begin
                if (model_wp >= TABLE_DEPTH_DEF) begin
                  model_err = STAT_OVERFLOW;
                  break;
                end
                class_model[model_wp] = letter_cls;
                model_wp++;
                n--;
              end
              model_last = letter_cls;
              model_count = 0;
            end
          end
        end
      end
      REQ_END: begin
        if (model_err == STAT_OK) begin
          while (model_wp < TABLE_DEPTH_DEF) begin
            class_model[model_wp] = model_last;
            model_wp++;
          end
          model_count = 0;
        end
      end
      REQ_QUERY: begin
        cls = class_model[b];
        res.is_binary = cls[0];
        res.is_control = cls[1];
        if (!cls[1]) begin
          res.form = FORM_PLAIN;
          res.shown_char = b;
        end else if (!class_model[b ^ CARET_FLIP][1]) begin
          res.form = FORM_CARET;
          res.shown_char = b ^ CARET_FLIP;
        end else begin
          res.form = FORM_ESCAPE;
          res.shown_char = b;
        end
      end
      default: ;
    endcase
    res.status = model_err;
    return res;
  endfunction

  function automatic logic [7:0] pick_bad_letter();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_DOT || b == CHAR_C ||
               b == CHAR_B);
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 2))
      0:       return CHAR_DOT;
      1:       return CHAR_C;
      default: return CHAR_B;
    endcase
  endfunction

  // The sender works in bursts; valid stays high between items of one burst.
  task automatic send_item(input logic [1:0] req, input logic [7:0] b);
    in_item_t    it;
    int unsigned gap;
    it.req_type = req;
    it.data_byte = b;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_class_result(it));
    burst_left--;
    items_sent++;
    if (req == REQ_QUERY) queries_sent++;
  endtask

  // One run of the description: optional leading zeros, the decimal count, the letter.
  task automatic send_run(input int unsigned cnt, input logic [7:0] letter,
                          input int unsigned lead_zeros);
    string s;
    int    i;
    repeat (lead_zeros) send_item(REQ_LOAD, CHAR_ZERO);
    if (cnt > 0) begin
      s = $sformatf("%0d", cnt);
      for (i = 0; i < s.len(); i++) send_item(REQ_LOAD, s[i]);
    end
    send_item(REQ_LOAD, letter);
  endtask

  task automatic test_reset_state();
    send_item(REQ_QUERY, 8'h00);
    send_item(REQ_QUERY, 8'hff);
    send_item(REQ_QUERY, 8'h40);
    send_item(REQ_NONE, 8'hff);
    send_item(REQ_NONE, 8'h00);
  endtask

  task automatic test_directed_runs();
    send_run(3, CHAR_C, 0);
    send_run(0, CHAR_B, 0);
    // A count of zero still writes one entry.
    send_run(0, CHAR_DOT, 1);
    send_run(12, CHAR_C, 0);
    send_run(2, CHAR_B, 0);
    send_item(REQ_QUERY, 8'h01);
    send_item(REQ_QUERY, 8'h03);
    send_item(REQ_QUERY, 8'h04);
    send_item(REQ_QUERY, 8'h41);
    send_item(REQ_QUERY, 8'h12);
    send_item(REQ_QUERY, 8'h13);
  endtask

  // Well-formed runs with random counts and letters, kept short of the table end.
  task automatic test_random_description();
    int unsigned target;
    int unsigned room;
    int unsigned cnt;
    int unsigned k;
    target = $urandom_range(60, 230);
    while (model_wp < target) begin
      room = TABLE_DEPTH_DEF - 1 - model_wp;
      if ($urandom_range(0, 3) == 0) cnt = 0;
      else cnt = $urandom_range(1, (room < 24) ? room : 24);
      send_run(cnt, pick_letter(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
      k = $urandom_range(0, 3);
      repeat (k) begin
        if ($urandom_range(0, 1) == 0) send_item(REQ_QUERY, 8'($urandom_range(0, 255)));
        else send_item(REQ_QUERY, 8'($urandom_range(0, model_wp)));
      end
      if ($urandom_range(0, 7) == 0) send_item(REQ_NONE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_end_fill();
    wp_before_fill = model_wp;
    send_item(REQ_END, 8'($urandom_range(0, 255)));
    send_item(REQ_QUERY, 8'hff);
    send_item(REQ_QUERY, 8'hbf);
    send_item(REQ_QUERY, 8'($urandom_range(0, 255)));
  endtask

  // Only one error can stick per run, so the seed picks which one comes first.
  task automatic test_error_handling();
    took_overflow_path = $urandom_range(0, 1);
    if (took_overflow_path) begin
      // The count saturates and the letter overflows the filled table.
      send_run(999, CHAR_B, 0);
      send_item(REQ_LOAD, pick_bad_letter());
    end else begin
      send_item(REQ_LOAD, pick_bad_letter());
      send_run(5, CHAR_C, 0);
    end
    send_item(REQ_END, 8'h00);
    send_item(REQ_QUERY, 8'h00);
  endtask

  task automatic test_random_queries();
    int unsigned goal;
    int unsigned pick;
    goal = queries_sent + 1600;
    while (queries_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) send_item(REQ_QUERY, 8'($urandom_range(0, 255)));
      else if (pick < 89) send_item(REQ_NONE, 8'($urandom_range(0, 255)));
      else if (pick < 95) send_item(REQ_LOAD, 8'($urandom_range(0, 255)));
      else send_item(REQ_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, actual %h", $time, out_item_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_item_o.status !== want.status || out_item_o.is_binary !== want.is_binary ||
            out_item_o.is_control !== want.is_control || out_item_o.form !== want.form ||
            out_item_o.shown_char !== want.shown_char) begin
          errors++;
          $display("%0t: mismatch expected status=%0d bin=%0b ctl=%0b form=%0d char=%02h",
                   $time, want.status, want.is_binary, want.is_control, want.form,
                   want.shown_char);
          $display("%0t:          actual status=%0d bin=%0b ctl=%0b form=%0d char=%02h",
                   $time, out_item_o.status, out_item_o.is_binary, out_item_o.is_control,
                   out_item_o.form, out_item_o.shown_char);
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_left % 7 == 0);
    endcase
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) class_model[i] = CLS_NORMAL;
    model_wp = 0;
    model_count = 0;
    model_last = CLS_NORMAL;
    model_err = STAT_OK;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_runs();
    test_random_description();
    test_end_fill();
    test_error_handling();
    test_random_queries();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items (%0d queries), %0d results checked.", items_sent,
             queries_sent, results_checked);
    $display("Table loaded to entry %0d before the end fill; sticky error taken: %s.",
             wp_before_fill, took_overflow_path ? "overflow" : "invalid letter");
    if (errors == 0) begin
      $display("char_class_table_rle_loader_core_tb: done, clean");
    end else begin
      $display("char_class_table_rle_loader_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("char_class_table_rle_loader_core_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cctrl_pkg.sv
rtl/core/cctrl_datapath.sv
rtl/core/cctrl_ctrl.sv
rtl/core/char_class_table_rle_loader_core.sv
sim/char_class_table_rle_loader_core_tb.sv
